### sv/assert_macros.svh
// Assertion helpers, included by the top-level file to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, switched off while rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge of clk, during reset as well.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/bm25tk_pkg.sv
package bm25tk_pkg;

  localparam int TOP_K  = 10;
  localparam int IDX_W  = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int CNT_W  = $clog2(TOP_K + 1);

  localparam int DOC_W   = 24;
  localparam int SCORE_W = 32;
  localparam int LEN_W   = 16;
  localparam int TF_W    = 8;
  localparam int IDF_W   = 16;
  localparam int K1_W    = 16;
  localparam int B_W     = 13;
  localparam int INV_W   = 24;
  localparam int CFG_W   = 24;
  localparam int CFGI_W  = 2;

  localparam int RATIO_W = LEN_W + INV_W;          // 40
  localparam int NORM_W  = 42;
  localparam int DEN_W   = 35;
  localparam int NUM1_W  = IDF_W + K1_W + 1;       // 33
  localparam int NUM_W   = NUM1_W + TF_W;          // 41
  localparam int DIVD_W  = NUM_W + 5;              // 46
  localparam int DIVC_W  = $clog2(DIVD_W);

  localparam logic [CFGI_W-1:0] REG_K1_GAIN  = 2'd0;
  localparam logic [CFGI_W-1:0] REG_LEN_WGT  = 2'd1;
  localparam logic [CFGI_W-1:0] REG_INV_AVG  = 2'd2;

  localparam logic [K1_W-1:0]  K1_RESET  = 16'd4915;
  localparam logic [B_W-1:0]   B_RESET   = 13'd3072;
  localparam logic [INV_W-1:0] INV_RESET = 24'd300044;
  localparam logic [B_W-1:0]   B_ONE     = 13'd4096;

  localparam logic CMD_SCORE = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic              command;
    logic [DOC_W-1:0]  doc_id;
    logic [LEN_W-1:0]  doc_len;
    logic [TF_W-1:0]   term_freq;
    logic [IDF_W-1:0]  idf_weight;
    logic              last_term;
  } in_item_t;

  typedef struct packed {
    logic             load_in;
    logic             mul1;
    logic             mul2;
    logic             mul3;
    logic             div_step;
    logic             acc;
    logic             append;
    logic             scan_first;
    logic             scan_step;
    logic             replace;
    logic             clr_sum;
    logic             dscan_first;
    logic             dscan_step;
    logic             emit;
    logic             emit_empty;
    logic             emit_last;
    logic             clr_count;
    logic             clr_emitted;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic             is_drain;
    logic             last_term;
    logic             out_busy;
    logic [CNT_W-1:0] count;
  } dp_sts_t;

  // True when entry a ranks ahead of entry b.
  function automatic logic ranks_before(input logic [SCORE_W-1:0] sa,
                                        input logic [DOC_W-1:0] da,
                                        input logic [SCORE_W-1:0] sb,
                                        input logic [DOC_W-1:0] db);
    ranks_before = (sa > sb) || ((sa == sb) && (da < db));
  endfunction

endpackage

### sv/bm25tk_in_if.sv
interface bm25tk_in_if;
  import bm25tk_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [DOC_W-1:0]  doc_id;
  logic [LEN_W-1:0]  doc_len;
  logic [TF_W-1:0]   term_freq;
  logic [IDF_W-1:0]  idf_weight;
  logic              last_term;
  modport source (output valid, command, doc_id, doc_len, term_freq, idf_weight, last_term,
                  input ready);
  modport sink (input valid, command, doc_id, doc_len, term_freq, idf_weight, last_term,
                output ready);
endinterface

### sv/bm25tk_out_if.sv
interface bm25tk_out_if;
  import bm25tk_pkg::*;
  logic               valid;
  logic               ready;
  logic [DOC_W-1:0]   out_doc_id;
  logic [SCORE_W-1:0] out_score;
  logic               found;
  logic               last;
  modport source (output valid, out_doc_id, out_score, found, last, input ready);
  modport sink (input valid, out_doc_id, out_score, found, last, output ready);
endinterface

### sv/bm25tk_datapath.sv
module bm25tk_datapath
  import bm25tk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFGI_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  in_item_t           in_item,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [DOC_W-1:0]   out_doc_id,
  output logic [SCORE_W-1:0] out_score,
  output logic               out_found,
  output logic               out_last
);

  logic [K1_W-1:0]  k1_r;
  logic [B_W-1:0]   b_r;
  logic [INV_W-1:0] inv_r;

  logic             drain_r;
  logic [DOC_W-1:0] doc_r;
  logic [LEN_W-1:0] len_r;
  logic [TF_W-1:0]  tf_r;
  logic [IDF_W-1:0] idf_r;
  logic             last_r;

  logic [RATIO_W-1:0] ratio_r;
  logic [NUM1_W-1:0]  num1_r;
  logic [NORM_W-1:0]  norm_r;
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   den_r;
  logic [DEN_W-1:0]   rem_r;
  logic [DIVD_W-1:0]  quo_r;

  logic [SCORE_W-1:0] sum_r;
  logic [CNT_W-1:0]   count_r;

  logic [DOC_W-1:0]   ent_doc_r   [TOP_K];
  logic [SCORE_W-1:0] ent_score_r [TOP_K];
  logic [TOP_K-1:0]   emitted_r;

  logic [IDX_W-1:0]   sel_idx_r;
  logic [DOC_W-1:0]   sel_doc_r;
  logic [SCORE_W-1:0] sel_score_r;
  logic               sel_have_r;

  logic               out_valid_r;
  logic [DOC_W-1:0]   out_doc_r;
  logic [SCORE_W-1:0] out_score_r;
  logic               out_found_r;
  logic               out_last_r;

  logic [B_W-1:0]        b_eff;
  logic [B_W-1:0]        b_comp;
  logic [53:0]           norm_sum;
  logic [57:0]           kq_prod;
  logic [DEN_W:0]        trial;
  logic                  ge;
  logic [SCORE_W-1:0]    term;
  logic [SCORE_W:0]      sum_add;
  logic [DOC_W-1:0]      rd_doc;
  logic [SCORE_W-1:0]    rd_score;
  logic                  low_take;
  logic                  best_take;

  assign b_eff    = (b_r > B_ONE) ? B_ONE : b_r;
  assign b_comp   = B_ONE - b_eff;
  assign norm_sum = 54'({b_comp, 24'd0}) + (54'(b_eff) * 54'(ratio_r));
  assign kq_prod  = 58'(k1_r) * 58'(norm_r);

  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    if (den_r == '0) begin
      term = '0;
    end else if (|quo_r[DIVD_W-1:SCORE_W]) begin
      term = '1;
    end else begin
      term = quo_r[SCORE_W-1:0];
    end
  end
  assign sum_add = {1'b0, sum_r} + {1'b0, term};

  assign rd_doc   = ent_doc_r[cmd.idx];
  assign rd_score = ent_score_r[cmd.idx];

  // The lowest entry is the one that every other entry ranks ahead of.
  assign low_take  = cmd.scan_first ||
                     ranks_before(sel_score_r, sel_doc_r, rd_score, rd_doc);
  assign best_take = !emitted_r[cmd.idx] &&
                     (cmd.dscan_first || !sel_have_r ||
                      ranks_before(rd_score, rd_doc, sel_score_r, sel_doc_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r  <= K1_RESET;
      b_r   <= B_RESET;
      inv_r <= INV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_K1_GAIN: k1_r  <= cfg_wdata[K1_W-1:0];
        REG_LEN_WGT: b_r   <= cfg_wdata[B_W-1:0];
        REG_INV_AVG: inv_r <= cfg_wdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      drain_r <= in_item.command;
      doc_r   <= in_item.doc_id;
      len_r   <= in_item.doc_len;
      tf_r    <= in_item.term_freq;
      idf_r   <= in_item.idf_weight;
      last_r  <= in_item.last_term;
    end
    if (cmd.mul1) begin
      ratio_r <= RATIO_W'(len_r) * RATIO_W'(inv_r);
      num1_r  <= NUM1_W'(idf_r) * (NUM1_W'(k1_r) + NUM1_W'(B_ONE));
    end
    if (cmd.mul2) begin
      norm_r <= norm_sum[12 +: NORM_W];
      num_r  <= NUM_W'(num1_r) * NUM_W'(tf_r);
    end
    if (cmd.mul3) begin
      den_r <= DEN_W'(kq_prod[57:24]) + DEN_W'({tf_r, 12'd0});
      rem_r <= '0;
      quo_r <= {num_r, 5'd0};
    end else if (cmd.div_step) begin
      rem_r <= ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_r <= {quo_r[DIVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cmd.acc) begin
      sum_r <= sum_add[SCORE_W] ? '1 : sum_add[SCORE_W-1:0];
    end else if (cmd.clr_sum) begin
      sum_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.append) begin
      count_r <= count_r + 1'b1;
    end else if (cmd.clr_count) begin
      count_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      ent_doc_r[count_r[IDX_W-1:0]]   <= doc_r;
      ent_score_r[count_r[IDX_W-1:0]] <= sum_r;
    end else if (cmd.replace && (sum_r > sel_score_r)) begin
      ent_doc_r[sel_idx_r]   <= doc_r;
      ent_score_r[sel_idx_r] <= sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.scan_step && low_take) || (cmd.dscan_step && best_take)) begin
      sel_idx_r   <= cmd.idx;
      sel_doc_r   <= rd_doc;
      sel_score_r <= rd_score;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_have_r <= 1'b0;
      emitted_r  <= '0;
    end else begin
      if (cmd.dscan_step) begin
        sel_have_r <= best_take || (!cmd.dscan_first && sel_have_r);
      end
      if (cmd.clr_emitted) begin
        emitted_r <= '0;
      end else if (cmd.emit) begin
        emitted_r[sel_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_empty) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_doc_r   <= sel_doc_r;
      out_score_r <= sel_score_r;
      out_found_r <= 1'b1;
      out_last_r  <= cmd.emit_last;
    end else if (cmd.emit_empty) begin
      out_doc_r   <= '0;
      out_score_r <= '0;
      out_found_r <= 1'b0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_doc_id = out_doc_r;
  assign out_score  = out_score_r;
  assign out_found  = out_found_r;
  assign out_last   = out_last_r;

  assign sts.is_drain  = drain_r;
  assign sts.last_term = last_r;
  assign sts.out_busy  = out_valid_r;
  assign sts.count     = count_r;

endmodule

### sv/bm25tk_ctrl.sv
module bm25tk_ctrl
  import bm25tk_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_command,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL1  = 4'd1;
  localparam logic [3:0] S_MUL2  = 4'd2;
  localparam logic [3:0] S_MUL3  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_INS   = 4'd6;
  localparam logic [3:0] S_LSCAN = 4'd7;
  localparam logic [3:0] S_LREP  = 4'd8;
  localparam logic [3:0] S_DSCAN = 4'd9;
  localparam logic [3:0] S_DEMIT = 4'd10;
  localparam logic [3:0] S_DWAIT = 4'd11;
  localparam logic [3:0] S_EMPTY = 4'd12;

  logic [3:0]        state_r, state_nxt;
  logic [DIVC_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  emit_cnt_r, emit_cnt_nxt;
  logic              done_r, done_nxt;
  logic              idx_end_cnt;
  logic              emit_final;

  assign idx_end_cnt = (CNT_W'(idx_r) + 1'b1) == sts.count;
  assign emit_final  = (emit_cnt_r + 1'b1) == sts.count;

  always_comb begin
    state_nxt    = state_r;
    div_cnt_nxt  = div_cnt_r;
    idx_nxt      = idx_r;
    emit_cnt_nxt = emit_cnt_r;
    done_nxt     = done_r;
    cmd          = '0;
    cmd.idx      = idx_r;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          idx_nxt     = '0;
          if (in_command == CMD_DRAIN) begin
            emit_cnt_nxt    = '0;
            cmd.clr_emitted = 1'b1;
            state_nxt       = (sts.count == '0) ? S_EMPTY : S_DSCAN;
          end else begin
            state_nxt = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3    = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DIVC_W'(DIVD_W - 1)) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last_term ? S_INS : S_IDLE;
      end
      S_INS: begin
        if (sts.count == CNT_W'(TOP_K)) begin
          idx_nxt   = '0;
          state_nxt = S_LSCAN;
        end else begin
          cmd.append  = 1'b1;
          cmd.clr_sum = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_LSCAN: begin
        cmd.scan_step  = 1'b1;
        cmd.scan_first = (idx_r == '0);
        idx_nxt        = idx_r + 1'b1;
        if (idx_r == IDX_W'(TOP_K - 1)) begin
          state_nxt = S_LREP;
        end
      end
      S_LREP: begin
        cmd.replace = 1'b1;
        cmd.clr_sum = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_DSCAN: begin
        cmd.dscan_step  = 1'b1;
        cmd.dscan_first = (idx_r == '0);
        idx_nxt         = idx_r + 1'b1;
        if (idx_end_cnt) begin
          state_nxt = S_DEMIT;
        end
      end
      S_DEMIT: begin
        if (!sts.out_busy) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = emit_final;
          cmd.clr_count = emit_final;
          done_nxt      = emit_final;
          emit_cnt_nxt  = emit_cnt_r + 1'b1;
          idx_nxt       = '0;
          state_nxt     = S_DWAIT;
        end
      end
      S_EMPTY: begin
        if (!sts.out_busy) begin
          cmd.emit_empty = 1'b1;
          done_nxt       = 1'b1;
          state_nxt      = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (done_r) begin
          if (!sts.out_busy) begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_DSCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      div_cnt_r  <= '0;
      idx_r      <= '0;
      emit_cnt_r <= '0;
      done_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      div_cnt_r  <= div_cnt_nxt;
      idx_r      <= idx_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      done_r     <= (state_nxt == S_IDLE) ? 1'b0 : done_nxt;
    end
  end

endmodule

### sv/bm25_topk_scorer_top.sv
// Fixed-point BM25 scorer with a ranked list of the best TOP_K documents.
// A score request takes one posting, works out the term weight and adds it,
// saturating, to the sum of the open document; a posting marked last_term
// closes the document and offers its sum to the ranked list. A drain request
// returns the list best first (ties go to the lower doc_id) and empties it,
// or returns a single not-found result when the list is empty. Only one
// request is in flight at a time. A score request runs through three multiply
// stages and a restoring divider that retires one quotient bit per cycle, and
// the next request is accepted only once it has finished.
// When the list is full, closing a document finds the lowest entry by stepping
// through the ten entries one per cycle. A drain finds each result by stepping
// through the list one entry per cycle, and holds off while a result is untaken.
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata
// and must only be changed while no request is in progress.
`include "assert_macros.svh"

module bm25_topk_scorer_top
  import bm25tk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  bm25tk_in_if.sink         in_req,
  bm25tk_out_if.source      out_res
);

  in_item_t in_item;
  dp_cmd_t  cmd;
  dp_sts_t  sts;
  logic     in_ready;

  // Gather the request payload into one item for the datapath.
  assign in_item.command    = in_req.command;
  assign in_item.doc_id     = in_req.doc_id;
  assign in_item.doc_len    = in_req.doc_len;
  assign in_item.term_freq  = in_req.term_freq;
  assign in_item.idf_weight = in_req.idf_weight;
  assign in_item.last_term  = in_req.last_term;
  assign in_req.ready       = in_ready;

  bm25tk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_command (in_req.command),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bm25tk_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_item    (in_item),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_res.ready),
    .out_valid  (out_res.valid),
    .out_doc_id (out_res.out_doc_id),
    .out_score  (out_res.out_score),
    .out_found  (out_res.found),
    .out_last   (out_res.last)
  );

  // A new request is only taken once every result of the last one has gone.
  `ASSERT_CLK(a_idle_out_empty, in_req.ready |-> !out_res.valid, "ready while result pending")
  // The ranked list never holds more than TOP_K entries.
  `ASSERT_CLK(a_count_bound, sts.count <= CNT_W'(TOP_K), "ranked count above TOP_K")
  // A not-found result is always the only result of its drain.
  `ASSERT_CLK(a_empty_last, (out_res.valid && !out_res.found) |-> out_res.last, "empty not last")
  // After the final result of a drain the list is empty.
  `ASSERT_CLK(a_drain_clears, (out_res.valid && out_res.ready && out_res.last) |=> (sts.count == '0), "list not cleared")

endmodule

### sim/tb_bm25_topk_scorer_top.sv
`timescale 1ns / 1ps

module tb_bm25_topk_scorer_top;
  import bm25tk_pkg::*;

  // One ranked result as it should leave the block.
  typedef struct {
    logic [DOC_W-1:0]   doc_id;
    logic [SCORE_W-1:0] score;
    logic               found;
    logic               last;
  } rank_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFGI_W-1:0] cfg_index = REG_K1_GAIN;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  bm25tk_in_if  in_bus();
  bm25tk_out_if out_bus();

  bm25_topk_scorer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_bus.sink),
    .out_res   (out_bus.source)
  );

  always #6 clk = ~clk;

  // Requests waiting to be offered, and the ranked results still owed by the block.
  in_item_t     pending_reqs[$];
  rank_result_t expected_ranks[$];

  // Our own copy of the configuration and of the block's scoring state.
  logic [K1_W-1:0]    k1_q = K1_RESET;
  logic [B_W-1:0]     b_q = B_RESET;
  logic [INV_W-1:0]   inv_q = INV_RESET;
  logic [SCORE_W-1:0] open_sum = '0;
  logic [DOC_W-1:0]   rank_doc[TOP_K];
  logic [SCORE_W-1:0] rank_score[TOP_K];
  int                 rank_n = 0;

  int  mismatches = 0;
  bit  in_taken = 1'b0;
  bit  calm = 1'b0;      // while set, neither side idles
  bit  hold_out = 1'b0;  // while set, the receiver refuses all results

  function automatic bit ahead(logic [SCORE_W-1:0] sa, logic [DOC_W-1:0] da,
                               logic [SCORE_W-1:0] sb, logic [DOC_W-1:0] db);
    return (sa > sb) || ((sa == sb) && (da < db));
  endfunction

  // BM25 term weight in Q16.16, truncating at every step as the hardware does.
  function automatic logic [SCORE_W-1:0] bm25_term(logic [LEN_W-1:0] len,
                                                   logic [TF_W-1:0] tf,
                                                   logic [IDF_W-1:0] idf);
    logic [63:0] b, ratio, norm, kq, den, num, t;
    b = (b_q > B_ONE) ? 64'd4096 : 64'(b_q);
    ratio = 64'(len) * 64'(inv_q);
    norm = (((64'd4096 - b) << 24) + b * ratio) >> 12;
    kq = (64'(k1_q) * norm) >> 24;
    den = kq + (64'(tf) << 12);
    if (den == 0) return '0;
    num = 64'(idf) * (64'(k1_q) + 64'd4096) * 64'(tf);
    t = (num << 5) / den;
    return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  // A closed document is appended while there is room, otherwise it displaces
  // the lowest-ranked entry only when its sum is strictly higher.
  function automatic void rank_document(logic [DOC_W-1:0] doc, logic [SCORE_W-1:0] sum);
    int low;
    low = 0;
    if (rank_n < TOP_K) begin
      rank_doc[rank_n] = doc;
      rank_score[rank_n] = sum;
      rank_n++;
      return;
    end
    for (int i = 1; i < TOP_K; i++)
      if (ahead(rank_score[low], rank_doc[low], rank_score[i], rank_doc[i])) low = i;
    if (sum > rank_score[low]) begin
      rank_doc[low] = doc;
      rank_score[low] = sum;
    end
  endfunction

  function automatic void drain_ranking();
    logic [DOC_W-1:0]   d[TOP_K];
    logic [SCORE_W-1:0] s[TOP_K];
    rank_result_t r;
    int best;
    if (rank_n == 0) begin
      r = '{doc_id: '0, score: '0, found: 1'b0, last: 1'b1};
      expected_ranks = {expected_ranks, r};
      return;
    end
    d = rank_doc;
    s = rank_score;
    for (int k = 0; k < rank_n; k++) begin
      best = k;
      for (int i = k + 1; i < rank_n; i++)
        if (ahead(s[i], d[i], s[best], d[best])) best = i;
      {d[k], d[best]} = {d[best], d[k]};
      {s[k], s[best]} = {s[best], s[k]};
      r = '{doc_id: d[k], score: s[k], found: 1'b1, last: (k + 1 == rank_n)};
      expected_ranks = {expected_ranks, r};
    end
    rank_n = 0;
  endfunction

  function automatic void take_request(in_item_t it);
    logic [SCORE_W-1:0] t, s;
    if (it.command == CMD_DRAIN) begin
      drain_ranking();
      return;
    end
    t = bm25_term(it.doc_len, it.term_freq, it.idf_weight);
    s = open_sum + t;
    open_sum = (s < t) ? 32'hFFFF_FFFF : s;
    if (it.last_term) begin
      rank_document(it.doc_id, open_sum);
      open_sum = '0;
    end
  endfunction

  // Acceptance of requests feeds the predictor; results are checked in order.
  always @(posedge clk) begin : monitor
    rank_result_t want;
    in_taken = rst_n && in_bus.valid && in_bus.ready;
    if (in_taken)
      take_request('{in_bus.command, in_bus.doc_id, in_bus.doc_len, in_bus.term_freq,
                     in_bus.idf_weight, in_bus.last_term});
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_ranks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: doc %0d score %0h found %0b last %0b",
                   out_bus.out_doc_id, out_bus.out_score, out_bus.found, out_bus.last);
      end else begin
        want = expected_ranks.pop_front();
        if (out_bus.out_doc_id !== want.doc_id || out_bus.out_score !== want.score ||
            out_bus.found !== want.found || out_bus.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected doc %0d score %0h found %0b last %0b, got doc %0d score %0h found %0b last %0b",
                     want.doc_id, want.score, want.found, want.last, out_bus.out_doc_id,
                     out_bus.out_score, out_bus.found, out_bus.last);
        end
      end
    end
  end

  // Both sides change on the falling edge; each idles at random about six percent of the time.
  initial begin
    in_bus.valid = 1'b0;
    {in_bus.command, in_bus.doc_id, in_bus.doc_len, in_bus.term_freq,
     in_bus.idf_weight, in_bus.last_term} = '0;
    out_bus.ready = 1'b0;
  end

  always @(negedge clk) begin : driver
    in_item_t it;
    if (rst_n) begin
      if (!in_bus.valid || in_taken) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
          it = pending_reqs.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.command <= it.command;
          in_bus.doc_id <= it.doc_id;
          in_bus.doc_len <= it.doc_len;
          in_bus.term_freq <= it.term_freq;
          in_bus.idf_weight <= it.idf_weight;
          in_bus.last_term <= it.last_term;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      out_bus.ready <= !hold_out && (calm || $urandom_range(99) >= 6);
    end
  end

  // The receiver refuses everything for a long stretch right after reset, so the
  // result of the opening drain sits untaken while postings keep being offered
  // and the input stalls. A quiet stretch without idling follows later.
  initial begin
    wait (rst_n);
    hold_out = 1'b1;
    repeat (400) @(negedge clk);
    hold_out = 1'b0;
    repeat (800) @(negedge clk);
    calm = 1'b1;
    repeat (800) @(negedge clk);
    calm = 1'b0;
  end

  // The watchdog: far above the slowest legal run.
  initial begin
    #12_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic write_reg(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_K1_GAIN: k1_q = val[K1_W-1:0];
      REG_LEN_WGT: b_q = val[B_W-1:0];
      REG_INV_AVG: inv_q = val[INV_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_weights(int k1, int b, int inv);
    write_reg(REG_K1_GAIN, CFG_W'(k1));
    write_reg(REG_LEN_WGT, CFG_W'(b));
    write_reg(REG_INV_AVG, CFG_W'(inv));
  endtask

  task automatic posting(int doc, int len, int tf, int idf, bit last);
    in_item_t it;
    it = '{CMD_SCORE, DOC_W'(doc), LEN_W'(len), TF_W'(tf), IDF_W'(idf), last};
    pending_reqs = {pending_reqs, it};
  endtask

  // The other fields of a drain carry noise, as the block must ignore them.
  task automatic drain();
    in_item_t it;
    it = '{CMD_DRAIN, DOC_W'($urandom), LEN_W'($urandom), TF_W'($urandom),
           IDF_W'($urandom), 1'($urandom)};
    pending_reqs = {pending_reqs, it};
  endtask

  // Score requests produce nothing, so after the last result the block may
  // still be busy closing a document; the pause covers a full scoring pass.
  task automatic settle();
    while (pending_reqs.size() > 0 || in_bus.valid || expected_ranks.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Mostly well-formed documents of one to four postings with random content,
  // with drains sprinkled in, some of them landing inside a document.
  task automatic random_phase(int n);
    int made, terms;
    made = 0;
    while (made < n) begin
      if ($urandom_range(9) == 0) begin
        drain();
        made++;
      end else begin
        terms = $urandom_range(4, 1);
        for (int t = 0; t < terms; t++) begin
          posting($urandom_range(20) == 0 ? 0 : $urandom_range(24'hFFFFFF),
                  $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(300),
                  $urandom_range(7) == 0 ? 0 : $urandom_range(255),
                  $urandom_range(65535), t == terms - 1);
          if (t < terms - 1 && $urandom_range(15) == 0) drain();
        end
        made += terms;
      end
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset weights: an empty drain first, then more equal documents than the
    // list holds, so the equal-score rule and the lowest-entry choice are seen.
    drain();
    for (int i = 0; i < 12; i++)
      posting(i == 0 ? 24'hFFFFFF : (i == 1 ? 0 : (i % 4) * 1000), 56, 3, 4000, 1'b1);
    posting(77, 56, 3, 4000, 1'b1);
    drain();
    // An open document survives a drain, and only the closing posting's id counts.
    posting(500, 65535, 255, 65535, 1'b0);
    drain();
    posting(600, 0, 1, 1, 1'b1);
    posting(700, 10, 200, 65535, 1'b1);
    drain();
    settle();

    // All weights at zero: a zero-frequency posting has a zero denominator.
    set_weights(0, 0, 0);
    posting(1, 123, 0, 65535, 1'b1);
    posting(2, 65535, 5, 65535, 1'b0);
    posting(3, 0, 255, 0, 1'b1);
    drain();
    settle();

    // Everything at its top: a length weight above one acts as exactly one.
    set_weights(65535, 8191, 16777215);
    for (int i = 0; i < 4; i++) posting(42, 0, 255, 65535, i == 3);
    posting(43, 65535, 255, 65535, 1'b1);
    drain();
    settle();

    set_weights(4915, 4096, 300044);
    random_phase(22);
    settle();
    set_weights($urandom_range(65535), $urandom_range(8191), $urandom_range(24'hFFFFFF));
    random_phase(22);
    settle();
    set_weights($urandom_range(8192), $urandom_range(4096), $urandom_range(600000));
    random_phase(22);
    settle();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
